FILE: rtl/rgr_pkg.sv
// Shared types, constants and glyph rendering for the readout glyph renderer.
// Used by rgr_front, rgr_job_fifo, rgr_back and readout_glyph_renderer; no dependencies.
package rgr_pkg;

  localparam int READING_W    = 24;
  localparam int VAL_W        = 24;
  localparam int BCD_DIGITS   = 5;
  localparam int BCD_W        = 4 * BCD_DIGITS;
  localparam int DD_PER_CYCLE = 3;
  localparam int DD_CYCLES    = VAL_W / DD_PER_CYCLE;
  localparam int DD_CNT_W     = $clog2(DD_CYCLES);
  localparam int JOB_QUEUE_DEPTH = 2;

  localparam logic [4:0] LEN_DIST  = 5'd17;
  localparam logic [4:0] LEN_ANGLE = 5'd19;

  localparam logic [6:0] DIST_COL  = 7'h34;
  localparam logic [2:0] DIST_PAGE = 3'd7;
  localparam logic [6:0] ELEV_COL  = 7'h4C;
  localparam logic [2:0] ELEV_PAGE = 3'd3;
  localparam logic [6:0] CANT_COL  = 7'h36;
  localparam logic [2:0] CANT_PAGE = 3'd1;

  typedef enum logic [2:0] {
    MODE_ERR,
    MODE_DASH,
    MODE_DIST,
    MODE_ELEV,
    MODE_CANT
  } job_mode_t;

  typedef enum logic [2:0] {
    G_BLANK,
    G_DIGIT,
    G_E,
    G_R,
    G_L,
    G_PLUS,
    G_MINUS,
    G_DEG
  } glyph_t;

  // One classified reading waiting for rendering. digits[2] is the hundreds digit.
  typedef struct packed {
    job_mode_t       mode;
    logic            neg;
    logic [2:0][3:0] digits;
  } rgr_job_t;

  localparam logic [7:0] DIGIT_FONT [10][3] = '{
    '{8'hFE, 8'h82, 8'hFE}, '{8'h42, 8'hFE, 8'h02}, '{8'h9E, 8'h92, 8'hF2},
    '{8'h92, 8'h92, 8'hFE}, '{8'hF0, 8'h10, 8'hFE}, '{8'hF2, 8'h92, 8'h9E},
    '{8'hFE, 8'h92, 8'h9E}, '{8'h80, 8'h80, 8'hFE}, '{8'hFE, 8'h92, 8'hFE},
    '{8'hF0, 8'h90, 8'hFE}
  };
  localparam logic [7:0] GLYPH_E     [3] = '{8'hFE, 8'h92, 8'h92};
  localparam logic [7:0] GLYPH_R     [3] = '{8'hFE, 8'hB0, 8'hEE};
  localparam logic [7:0] GLYPH_L     [3] = '{8'hFE, 8'h02, 8'h02};
  localparam logic [7:0] GLYPH_DEG   [3] = '{8'hE0, 8'hA0, 8'hE0};
  localparam logic [7:0] GLYPH_PLUS  [3] = '{8'h10, 8'h38, 8'h10};
  localparam logic [7:0] GLYPH_MINUS [3] = '{8'h10, 8'h10, 8'h10};
  localparam logic [7:0] GLYPH_M     [5] = '{8'h1E, 8'h10, 8'h0E, 8'h10, 8'h0E};

  // Column c of a three-column glyph; column 3 is the blank spacer.
  function automatic logic [7:0] glyph_col(glyph_t g, logic [3:0] digit, logic [1:0] c);
    logic [7:0] b;
    b = 8'h00;
    if (c != 2'd3) begin
      unique case (g)
        G_DIGIT: b = DIGIT_FONT[digit][c];
        G_E:     b = GLYPH_E[c];
        G_R:     b = GLYPH_R[c];
        G_L:     b = GLYPH_L[c];
        G_PLUS:  b = GLYPH_PLUS[c];
        G_MINUS: b = GLYPH_MINUS[c];
        G_DEG:   b = GLYPH_DEG[c];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // Byte idx of the field that a job renders. Glyph slots are four columns wide;
  // the five-column "m" covers bytes 12 to 16.
  function automatic logic [7:0] render_byte(rgr_job_t job, logic [4:0] idx);
    logic [2:0] slot;
    logic [1:0] c;
    glyph_t     g;
    logic [3:0] dg;
    logic       m_zone;
    logic [2:0] m_col;
    logic [4:0] m_off;
    slot   = idx[4:2];
    c      = idx[1:0];
    g      = G_BLANK;
    dg     = 4'd0;
    m_zone = 1'b0;
    m_off  = idx - 5'd12;
    m_col  = m_off[2:0];
    unique case (job.mode)
      MODE_ERR: begin
        if (slot == 3'd0) begin
          g = G_E;
        end else if (slot <= 3'd2) begin
          g = G_R;
        end
      end
      MODE_DASH: begin
        if (slot <= 3'd2) begin
          g = G_MINUS;
        end else begin
          m_zone = 1'b1;
        end
      end
      MODE_DIST: begin
        if (slot <= 3'd2) begin
          g  = G_DIGIT;
          dg = job.digits[2'(3'd2 - slot)];
        end else begin
          m_zone = 1'b1;
        end
      end
      MODE_ELEV, MODE_CANT: begin
        if (slot == 3'd0) begin
          if (job.mode == MODE_ELEV) begin
            g = job.neg ? G_MINUS : G_PLUS;
          end else begin
            g = job.neg ? G_L : G_R;
          end
        end else if (slot <= 3'd3) begin
          g  = G_DIGIT;
          dg = job.digits[2'(3'd3 - slot)];
        end else begin
          g = G_DEG;
        end
      end
      default: g = G_BLANK;
    endcase
    return m_zone ? GLYPH_M[m_col] : glyph_col(g, dg, c);
  endfunction

endpackage

FILE: rtl/rgr_front.sv
// Front end: configuration registers, reading classification and decimal conversion.
// Depends on rgr_pkg; feeds rendering jobs into rgr_job_fifo.
module rgr_front
  import rgr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [READING_W-1:0] in_reading,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [READING_W-1:0] cfg_wdata,
  output logic                 push_valid,
  output rgr_job_t             push_job,
  input  logic                 q_full
);

  localparam logic [1:0] KIND_DIST = 2'd0;
  localparam logic [1:0] KIND_ELEV = 2'd1;
  localparam logic [1:0] KIND_CANT = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] CFG_HIDDEN     = 2'd0;
  localparam logic [1:0] CFG_DISCONNECT = 2'd1;
  localparam logic [1:0] CFG_FULL_RANGE = 2'd2;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_CONV = 3'b010,
    FS_PUSH = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic                        hidden_r;
  logic signed [READING_W-1:0] disconnect_r;
  logic signed [READING_W-1:0] full_range_r;

  logic [VAL_W-1:0]    bin_r, bin_nxt, bin_step;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt, bcd_step;
  logic [DD_CNT_W-1:0] cnt_r, cnt_nxt;
  job_mode_t           mode_r, mode_nxt, mode_in;
  logic                neg_r, neg_nxt;

  logic             accept;
  logic             keep;
  logic [VAL_W-1:0] dist_val;
  logic [VAL_W-1:0] mag;
  logic [VAL_W-1:0] whole;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidden_r     <= 1'b0;
      disconnect_r <= -24'sd1;
      full_range_r <= 24'sd4000;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_HIDDEN) begin
        hidden_r <= cfg_wdata[0];
      end else if (cfg_index == CFG_DISCONNECT) begin
        disconnect_r <= cfg_wdata;
      end else if (cfg_index == CFG_FULL_RANGE) begin
        full_range_r <= cfg_wdata;
      end
    end
  end

  // Classification of the incoming reading.
  always_comb begin
    keep     = !hidden_r && (in_kind != KIND_NONE);
    dist_val = in_reading[READING_W-1] ? '0 : in_reading;
    mag      = in_reading[READING_W-1] ? (~in_reading + 1'b1) : in_reading;
    whole    = mag >> ANGLE_FRAC_BITS;
    mode_in  = MODE_DIST;
    if (in_kind == KIND_DIST) begin
      if ($signed(in_reading) <= disconnect_r) begin
        mode_in = MODE_ERR;
      end else if ($signed(in_reading) == full_range_r) begin
        mode_in = MODE_DASH;
      end
    end else if (in_kind == KIND_ELEV) begin
      mode_in = MODE_ELEV;
    end else if (in_kind == KIND_CANT) begin
      mode_in = MODE_CANT;
    end
  end

  // Shift-and-add-3 conversion, a few bits per cycle; digits above the fifth drop
  // off the top, which keeps the value modulo 100000.
  always_comb begin
    bin_step = bin_r;
    bcd_step = bcd_r;
    for (int s = 0; s < DD_PER_CYCLE; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], bin_step[VAL_W-1]};
      bin_step = {bin_step[VAL_W-2:0], 1'b0};
    end
  end

  assign in_stall = !((state_r == FS_IDLE) || ((state_r == FS_PUSH) && !q_full));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    neg_nxt   = neg_r;
    if (state_r == FS_CONV) begin
      bin_nxt = bin_step;
      bcd_nxt = bcd_step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DD_CNT_W'(DD_CYCLES - 1)) begin
        state_nxt = FS_PUSH;
      end
    end else if (state_r == FS_PUSH && !q_full) begin
      state_nxt = FS_IDLE;
    end
    if (accept && keep) begin
      state_nxt = FS_CONV;
      bin_nxt   = (in_kind == KIND_DIST) ? dist_val : whole;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      mode_nxt  = mode_in;
      neg_nxt   = in_reading[READING_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    mode_r <= mode_nxt;
    neg_r  <= neg_nxt;
  end

  // Distance digits are the metre digits, which sit two places up in centimetres.
  always_comb begin
    push_valid    = (state_r == FS_PUSH);
    push_job.mode = mode_r;
    push_job.neg  = neg_r;
    if (mode_r == MODE_ELEV || mode_r == MODE_CANT) begin
      push_job.digits = bcd_r[11:0];
    end else begin
      push_job.digits = bcd_r[19:8];
    end
  end

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_job.digits[0] <= 4'd9) && (push_job.digits[1] <= 4'd9)
                   && (push_job.digits[2] <= 4'd9))
    else $error("front pushed a non-decimal digit");

  a_dropped_item_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_NONE || hidden_r) |=> state_r == FS_IDLE)
    else $error("suppressed item started a conversion");

endmodule

FILE: rtl/rgr_job_fifo.sv
// Short job queue between the classifying front end and the byte sequencer.
// Depends on rgr_pkg for the job type.
module rgr_job_fifo
  import rgr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  rgr_job_t push_job,
  output logic     full,
  output logic     head_valid,
  output rgr_job_t head_job,
  input  logic     pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rgr_job_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count beyond depth");

endmodule

FILE: rtl/rgr_back.sv
// Back end: walks the head job byte by byte and drives the registered result port.
// Depends on rgr_pkg for the job type, field placement and glyph rendering.
module rgr_back
  import rgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  rgr_job_t head_job,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output logic [7:0] out_column_byte,
  output logic [6:0] out_field_column,
  output logic [2:0] out_field_page,
  output logic     out_last
);

  logic [4:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic [6:0] col_r, col_nxt;
  logic [2:0] page_r, page_nxt;
  logic       last_r;
  logic       advance;
  logic       is_last;
  logic [4:0] len;

  assign advance = !valid_r || !out_stall;

  always_comb begin
    if (head_job.mode == MODE_ELEV || head_job.mode == MODE_CANT) begin
      len = LEN_ANGLE;
    end else begin
      len = LEN_DIST;
    end
    is_last = (idx_r == len - 5'd1);
    if (head_job.mode == MODE_ELEV) begin
      col_nxt  = ELEV_COL;
      page_nxt = ELEV_PAGE;
    end else if (head_job.mode == MODE_CANT) begin
      col_nxt  = CANT_COL;
      page_nxt = CANT_PAGE;
    end else begin
      col_nxt  = DIST_COL;
      page_nxt = DIST_PAGE;
    end
    pop       = advance && head_valid && is_last;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (advance) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        idx_nxt = is_last ? 5'd0 : idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      byte_r <= render_byte(head_job, idx_r);
      col_r  <= col_nxt;
      page_r <= page_nxt;
      last_r <= is_last;
    end
  end

  assign out_valid        = valid_r;
  assign out_column_byte  = byte_r;
  assign out_field_column = col_r;
  assign out_field_page   = page_r;
  assign out_last         = last_r;

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && head_valid && is_last |=> idx_r == 5'd0)
    else $error("byte index did not restart after a field");

  a_index_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < LEN_ANGLE)
    else $error("byte index ran past the longest field");

endmodule

FILE: rtl/readout_glyph_renderer.sv
// Top level of the readout glyph renderer: front end, job queue and byte sequencer.
// Depends on rgr_pkg, rgr_front, rgr_job_fifo and rgr_back.
//
//   Port group | Direction | Handshake         | Carries
//   in_*       | input     | in_valid/in_stall | kind, signed reading
//   out_*      | output    | out_valid/out_stall | column byte, field column/page, last
//   cfg_*      | input     | cfg_wr_en         | register index and write data
//
// Each field leaves one byte per cycle while out_stall is low: 17 bytes for a distance
// and 19 for an angle, so the byte sequencer sets the sustained rate of readings.
// The front end takes a new reading only once the last one is converted (8 conversion
// steps, then the queue push, which overlaps the next load) and runs ahead of the
// sequencer through a two-entry job queue.
// Reset is synchronous and active low; it restores the register defaults and empties
// the queue. A stalled result holds in the output register while the front keeps
// going until the job queue fills.
module readout_glyph_renderer
  import rgr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [READING_W-1:0] in_reading,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_column_byte,
  output logic [6:0]           out_field_column,
  output logic [2:0]           out_field_page,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [READING_W-1:0] cfg_wdata
);

  // Jobs move from the front end into the queue only when it has room; the
  // sequencer pops a job as its final byte enters the output register.
  logic     push_valid;
  rgr_job_t push_job;
  logic     q_full;
  logic     head_valid;
  rgr_job_t head_job;
  logic     pop;

  rgr_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_reading (in_reading),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  rgr_job_fifo #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  rgr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_byte  (out_column_byte),
    .out_field_column (out_field_column),
    .out_field_page   (out_field_page),
    .out_last         (out_last)
  );

endmodule
